// ===== rtl/hng_pkg.sv =====
// hng_pkg: shared constants, a state type and a helper function for the heightmap normal generator.
// No dependencies.
`default_nettype none
package hng_pkg;
    localparam int MAX_COLUMN_LENGTH = 256;
    localparam int SAMPLE_W  = 16;
    localparam int SCALE_W   = 16;
    localparam int LEN_W     = 9;
    localparam int HEIGHT_W  = 32;
    localparam int DIFF_W    = 21;
    localparam int SUMSQ_W   = 43;
    localparam int NORM_W    = 22;
    localparam int QUOT_W    = 16;
    localparam int DIV_W     = 39;
    localparam int COLCNT_W  = 16;
    localparam logic signed [DIFF_W-1:0] Z_CONST = 21'sd8192;
    localparam int CFG_W     = 16;
    localparam logic CFG_COLUMN_LENGTH = 1'b0;
    localparam logic CFG_HEIGHT_SCALE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_CALC, ST_SQRT, ST_DIV, ST_OUT
    } state_t;

    function automatic logic signed [DIFF_W-1:0] sat_diff(
        input logic [HEIGHT_W-1:0] a, input logic [HEIGHT_W-1:0] b);
        logic signed [HEIGHT_W:0] d;
        begin
            d = $signed({1'b0, a}) - $signed({1'b0, b});
            if (d > 33'sd1048575)
                sat_diff = 21'sd1048575;
            else if (d < -33'sd1048576)
                sat_diff = -21'sd1048576;
            else
                sat_diff = d[DIFF_W-1:0];
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/hng_stream_if.sv =====
// hng_stream_if: valid/ready channel with a generic payload type.
// Depends on nothing.
`default_nettype none
interface hng_stream_if #(parameter type payload_t = logic) (input wire logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/heightmap_normal_generator.sv =====
// heightmap_normal_generator: central-difference normals from a column-streamed height map.
// Steps per beat: store reads, setup, square, 22 sqrt steps, a divider run for each of
//   the three components, done, output load.
// Throughput: a new beat is taken only once the last is through (iterative sqrt/divider,
//   hng_norm); beats with no result skip it. A held output result stalls the next result.
// Reset (rst_n, async, low): counters zero, column_length 255, height_scale 410; stores undefined.
// Depends on hng_pkg, hng_stream_if, hng_ram, hng_norm.
`default_nettype none
module heightmap_normal_generator
    import hng_pkg::*;
#(
    parameter int MAX_LEN = MAX_COLUMN_LENGTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic           cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    hng_stream_if.sink          in_ch,
    hng_stream_if.source        out_ch
);
    localparam int AW = $clog2(MAX_LEN);

    state_t state_reg, state_next;
    logic [LEN_W-1:0]   len_cfg_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [AW-1:0]      row_reg;
    logic [COLCNT_W-1:0] col_reg;
    logic [COLCNT_W-1:0] col_eff;

    // Latched beat
    logic [SAMPLE_W-1:0] smp_reg;
    logic                pad_reg;
    logic [AW-1:0]       r_reg;
    logic                last_reg;
    logic                first_reg;
    logic                havel_reg;

    // Line store ports: middle read twice (row, row+1) in successive READ phases; prev read twice.
    logic            mid_we, prv_we;
    logic [AW-1:0]   mid_waddr, prv_waddr, mid_raddr, prv_raddr;
    logic [HEIGHT_W-1:0] mid_wdata, prv_wdata, mid_rdata, prv_rdata;
    logic [HEIGHT_W-1:0] here_reg, left_reg, up_reg, down_reg;
    logic [1:0]  phase_reg;

    logic [HEIGHT_W-1:0] right_v;
    logic [AW:0] len_c;
    logic [AW:0] row_eff;
    logic        in_last;
    logic        norm_start, norm_done;
    logic        out_load;
    logic signed [DIFF_W-1:0] dx_v, dy_v;
    logic signed [15:0] nx_v, ny_v;
    logic [14:0] nz_v;
    logic [15:0] onx_reg, ony_reg;
    logic [14:0] onz_reg;
    logic        ogd_reg;

    hng_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAX_LEN)) u_mid (
        .clk(clk), .we(mid_we), .waddr(mid_waddr), .wdata(mid_wdata),
        .raddr(mid_raddr), .rdata(mid_rdata));
    hng_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAX_LEN)) u_prv (
        .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
        .raddr(prv_raddr), .rdata(prv_rdata));

    // Effective length, clamped to 2..MAX_LEN
    always_comb
    begin
        if (len_cfg_reg < LEN_W'(2))
            len_c = (AW+1)'(2);
        else if (32'(len_cfg_reg) > MAX_LEN)
            len_c = (AW+1)'(MAX_LEN);
        else
            len_c = (AW+1)'(len_cfg_reg);
    end

    // Row and column of the incoming beat, with frame_start restart
    assign row_eff = in_ch.data.frame_start ? '0 : {1'b0, row_reg};
    assign col_eff = in_ch.data.frame_start ? '0 : col_reg;
    assign in_last = row_eff >= len_c - (AW+1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= LEN_W'(255);
            scale_reg   <= SCALE_W'(410);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_COLUMN_LENGTH)
                len_cfg_reg <= cfg_data[LEN_W-1:0];
            else
                scale_reg <= cfg_data;
        end
    end

    assign right_v = pad_reg ? here_reg : HEIGHT_W'(smp_reg) * HEIGHT_W'(scale_reg);
    assign dx_v = sat_diff(left_reg, right_v);
    assign dy_v = sat_diff(down_reg, up_reg);

    // Result moves to the output register once that register is free or draining
    assign out_load = (state_reg == ST_DIV) && (out_ch.ready || !out_ch.valid);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_ch.valid) state_next = ST_READ;
            ST_READ: if (first_reg) state_next = ST_OUT;
                     else if (phase_reg == 2'd2) state_next = ST_CALC;
            ST_CALC: state_next = ST_SQRT;
            ST_SQRT: if (norm_done) state_next = ST_DIV;
            ST_DIV:  if (out_load) state_next = ST_IDLE;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign norm_start  = (state_reg == ST_CALC);

    // Memory addressing: READ phase 0 reads mid[r], prv[r]; phase 1 mid[r+1], prv[r-1].
    always_comb
    begin
        mid_raddr = r_reg;
        prv_raddr = r_reg;
        if (phase_reg != 2'd0)
        begin
            mid_raddr = last_reg ? r_reg : AW'(r_reg + AW'(1));
            prv_raddr = (r_reg == '0) ? r_reg : AW'(r_reg - AW'(1));
        end
        mid_we = 1'b0; prv_we = 1'b0;
        mid_waddr = r_reg; prv_waddr = r_reg;
        mid_wdata = right_v; prv_wdata = here_reg;
        if (state_reg == ST_READ && first_reg && !pad_reg)
        begin
            mid_we = 1'b1;
        end
        if (state_reg == ST_CALC)
        begin
            prv_we = 1'b1;
            mid_we = !pad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            phase_reg <= '0;
            out_ch.valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_ch.valid <= 1'b1;
            else if (out_ch.valid && out_ch.ready)
                out_ch.valid <= 1'b0;
            if (in_ch.valid && in_ch.ready)
            begin
                phase_reg <= '0;
                // Counter update done at accept time; data path follows.
                if (col_eff == '0)
                begin
                    if (!in_ch.data.pad)
                    begin
                        row_reg <= in_last ? '0 : AW'(row_eff + (AW+1)'(1));
                        col_reg <= in_last ? COLCNT_W'(1) : '0;
                    end
                    else
                    begin
                        row_reg <= AW'(row_eff);
                        col_reg <= '0;
                    end
                end
                else if (in_last)
                begin
                    row_reg <= '0;
                    if (in_ch.data.pad)
                        col_reg <= '0;
                    else if (col_reg != '1)
                        col_reg <= col_reg + COLCNT_W'(1);
                end
                else
                    row_reg <= AW'(row_eff + (AW+1)'(1));
            end
            else if (state_reg == ST_READ)
                phase_reg <= phase_reg + 2'd1;
        end
    end

    // Beat capture and neighbor gathering
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            smp_reg   <= in_ch.data.height_sample;
            pad_reg   <= in_ch.data.pad;
            r_reg     <= (row_eff >= (AW+1)'(MAX_LEN)) ? AW'(MAX_LEN-1) : AW'(row_eff);
            last_reg  <= in_last;
            first_reg <= (col_eff == '0);
            havel_reg <= (col_eff >= COLCNT_W'(2));
        end
        if (state_reg == ST_READ && phase_reg == 2'd1)
        begin
            here_reg <= mid_rdata;
            left_reg <= havel_reg ? prv_rdata : mid_rdata;
        end
        if (state_reg == ST_READ && phase_reg == 2'd2)
        begin
            up_reg   <= last_reg ? here_reg : mid_rdata;
            down_reg <= (r_reg == '0) ? here_reg : prv_rdata;
        end
        if (out_load)
        begin
            onx_reg <= nx_v;
            ony_reg <= ny_v;
            onz_reg <= nz_v;
            ogd_reg <= last_reg && pad_reg;
        end
    end

    hng_norm u_norm (
        .clk(clk), .rst_n(rst_n), .start(norm_start), .dx(dx_v), .dy(dy_v),
        .done(norm_done), .nx(nx_v), .ny(ny_v), .nz(nz_v));

    assign out_ch.data.normal_x  = onx_reg;
    assign out_ch.data.normal_y  = ony_reg;
    assign out_ch.data.normal_z  = onz_reg;
    assign out_ch.data.grid_done = ogd_reg;
endmodule
`default_nettype wire

// ===== rtl/hng_ram.sv =====
// hng_ram: generic single-port-write, one-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module hng_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/hng_norm.sv =====
// hng_norm: normalizes (dx, dy, 8192) to Q1.15 with an iterative square root
// and an iterative restoring divider shared by the three components. Uses hng_pkg.
`default_nettype none
module hng_norm
    import hng_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [DIFF_W-1:0] dx,
    input  wire logic signed [DIFF_W-1:0] dy,
    output logic                          done,
    output logic signed [15:0]            nx,
    output logic signed [15:0]            ny,
    output logic [14:0]                   nz
);
    typedef enum logic [2:0] {N_IDLE, N_SQ, N_SQRT, N_DIV, N_DONE} nstate_t;
    nstate_t state_reg, state_next;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic [SUMSQ_W-1:0] rem_reg, rem_next;
    logic [SUMSQ_W-1:0] res_reg, res_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [1:0]  comp_reg, comp_next;
    logic [NORM_W-1:0] n_reg, n_next;
    logic [DIV_W-1:0]  dvd_reg, dvd_next;
    logic [NORM_W:0]   drem_reg, drem_next;
    logic [QUOT_W+8:0] q_reg, q_next;
    logic signed [15:0] nx_reg, nx_next, ny_reg, ny_next;
    logic [14:0] nz_reg, nz_next;
    logic [SUMSQ_W-1:0] sq_x, sq_y, bitv, trial;
    logic [DIFF_W-1:0] mag;
    logic neg;
    logic [NORM_W:0] shifted;
    logic [QUOT_W+8:0] qsat;

    assign sq_x = SUMSQ_W'($signed(dx_reg) * $signed(dx_reg));
    assign sq_y = SUMSQ_W'($signed(dy_reg) * $signed(dy_reg));
    assign bitv = SUMSQ_W'(1) << {cnt_reg, 1'b0};
    assign trial = res_reg + bitv;

    always_comb
    begin
        case (comp_reg)
            2'd0:    begin mag = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg); neg = dx_reg[DIFF_W-1]; end
            2'd1:    begin mag = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg); neg = dy_reg[DIFF_W-1]; end
            default: begin mag = DIFF_W'(Z_CONST); neg = 1'b0; end
        endcase
    end

    assign shifted = {drem_reg[NORM_W-1:0], dvd_reg[DIV_W-1]};

    always_comb
    begin
        state_next = state_reg;
        rem_next = rem_reg; res_next = res_reg; cnt_next = cnt_reg;
        comp_next = comp_reg; n_next = n_reg; dvd_next = dvd_reg;
        drem_next = drem_reg; q_next = q_reg;
        nx_next = nx_reg; ny_next = ny_reg; nz_next = nz_reg;
        qsat = '0;
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                    state_next = N_SQ;
            end
            N_SQ:
            begin
                rem_next = sq_x + sq_y + SUMSQ_W'(64'd67108864);
                res_next = '0;
                cnt_next = 6'd21;
                state_next = N_SQRT;
            end
            N_SQRT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_next = rem_reg - trial;
                    res_next = (res_reg >> 1) + bitv;
                end
                else
                    res_next = res_reg >> 1;
                if (cnt_reg == 6'd0)
                begin
                    comp_next = 2'd0;
                    state_next = N_DIV;
                    cnt_next = 6'(DIV_W);
                    n_next = '0;
                end
                else
                    cnt_next = cnt_reg - 6'd1;
            end
            N_DIV:
            begin
                if (cnt_reg == 6'(DIV_W))
                begin
                    if (comp_reg == 2'd0)
                        n_next = res_reg[NORM_W-1:0];
                    dvd_next = DIV_W'({mag, 15'd0}) +
                               DIV_W'((comp_reg == 2'd0 ? res_reg[NORM_W-1:0] : n_reg) >> 1);
                    drem_next = '0;
                    q_next = '0;
                    cnt_next = cnt_reg - 6'd1;
                end
                else
                begin
                    if (shifted >= {1'b0, n_reg})
                    begin
                        drem_next = shifted - {1'b0, n_reg};
                        q_next = {q_reg[QUOT_W+7:0], 1'b1};
                    end
                    else
                    begin
                        drem_next = shifted;
                        q_next = {q_reg[QUOT_W+7:0], 1'b0};
                    end
                    dvd_next = dvd_reg << 1;
                    if (cnt_reg == 6'd0)
                    begin
                        qsat = q_next;
                        cnt_next = 6'(DIV_W);
                        case (comp_reg)
                            2'd0:
                            begin
                                nx_next = neg ? ((qsat > 25'd32768) ? -16'sd32768 : 16'(-qsat))
                                              : ((qsat > 25'd32767) ? 16'sd32767 : 16'(qsat));
                                comp_next = 2'd1;
                            end
                            2'd1:
                            begin
                                ny_next = neg ? ((qsat > 25'd32768) ? -16'sd32768 : 16'(-qsat))
                                              : ((qsat > 25'd32767) ? 16'sd32767 : 16'(qsat));
                                comp_next = 2'd2;
                            end
                            default:
                            begin
                                nz_next = (qsat > 25'd32767) ? 15'h7fff : 15'(qsat);
                                state_next = N_DONE;
                            end
                        endcase
                    end
                    else
                        cnt_next = cnt_reg - 6'd1;
                end
            end
            N_DONE:  state_next = N_IDLE;
            default: state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= N_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dx_reg <= dx;
            dy_reg <= dy;
        end
        rem_reg <= rem_next; res_reg <= res_next; cnt_reg <= cnt_next;
        comp_reg <= comp_next; n_reg <= n_next; dvd_reg <= dvd_next;
        drem_reg <= drem_next; q_reg <= q_next;
        nx_reg <= nx_next; ny_reg <= ny_next; nz_reg <= nz_next;
    end

    assign done = (state_reg == N_DONE);
    assign nx = nx_reg;
    assign ny = ny_reg;
    assign nz = nz_reg;
endmodule
`default_nettype wire
